// ===== rtl/tpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types, constants and small decode functions of the triangle
// primitive assembler.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int IndexBits  = 16;   // width of an incoming vertex index
  localparam int VtxBits    = 17;   // vertex number / count width
  localparam int OffBits    = 24;   // byte offset width
  localparam int StrideBits = 8;
  localparam int SubOffBits = 6;    // colour / uv offset width
  localparam int MaxTexSets = 8;
  localparam int TexCntBits = 4;
  localparam int AddrBits   = 5;

  localparam logic [VtxBits-1:0] PosMax = {VtxBits{1'b1}};
  localparam logic [2:0]         PosFmtRhw = 3'd2;

  typedef enum logic [1:0] {
    PRIM_LIST  = 2'd0,
    PRIM_FAN   = 2'd1,
    PRIM_STRIP = 2'd2,
    PRIM_OTHER = 2'd3
  } prim_kind_t;

  typedef enum logic [2:0] {
    REG_PRIM_KIND   = 3'd0,
    REG_INDEXED     = 3'd1,
    REG_VTX_TOTAL   = 3'd2,
    REG_POS_FORMAT  = 3'd3,
    REG_ATTR_FLAGS  = 3'd4,
    REG_TEX_COUNT   = 3'd5,
    REG_TEX_SIZES   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    prim_kind_t          prim_kind;
    logic                indexed_mode;
    logic [VtxBits-1:0]  vertex_total;
    logic [2:0]          position_format;
    logic [2:0]          attribute_flags;
    logic [TexCntBits-1:0] tex_set_count;
    logic [15:0]         tex_set_sizes;
  } cfg_t;

  typedef struct packed {
    logic [StrideBits-1:0] stride;
    logic [SubOffBits-1:0] colour_off;
    logic [SubOffBits-1:0] uv_off;
  } fmt_t;

  // One assembled triangle on its way to the offset stage.
  typedef struct packed {
    logic               vld;
    logic [VtxBits-1:0] a;
    logic [VtxBits-1:0] b;
    logic [VtxBits-1:0] c;
  } tri_t;

  // Bytes taken by the position part of a vertex.
  function automatic logic [SubOffBits-1:0] pos_bytes(input logic [2:0] fmt);
    logic [SubOffBits-1:0] r;
    unique case (fmt)
      3'd0:    r = 6'd0;
      3'd1:    r = 6'd12;
      3'd2:    r = 6'd16;
      3'd3:    r = 6'd16;
      3'd4:    r = 6'd20;
      3'd5:    r = 6'd24;
      3'd6:    r = 6'd28;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

  // Bytes taken by one texture coordinate set: floats times four.
  function automatic logic [4:0] tex_set_bytes(input logic [1:0] code);
    logic [4:0] r;
    unique case (code)
      2'd0:    r = 5'd8;
      2'd1:    r = 5'd12;
      2'd2:    r = 5'd16;
      default: r = 5'd4;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tpa_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_cfg_regs
// APB register bank holding the draw call configuration.
// ----------------------------------------------------------------------------
module tpa_cfg_regs
  import tpa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[AddrBits-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PRIM_KIND:  cfg_nxt.prim_kind       = prim_kind_t'(pwdata[1:0]);
        REG_INDEXED:    cfg_nxt.indexed_mode    = pwdata[0];
        REG_VTX_TOTAL:  cfg_nxt.vertex_total    = pwdata[VtxBits-1:0];
        REG_POS_FORMAT: cfg_nxt.position_format = pwdata[2:0];
        REG_ATTR_FLAGS: cfg_nxt.attribute_flags = pwdata[2:0];
        REG_TEX_COUNT:  cfg_nxt.tex_set_count   = pwdata[TexCntBits-1:0];
        REG_TEX_SIZES:  cfg_nxt.tex_set_sizes   = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PRIM_KIND:  prdata = 32'(cfg_r.prim_kind);
      REG_INDEXED:    prdata = 32'(cfg_r.indexed_mode);
      REG_VTX_TOTAL:  prdata = 32'(cfg_r.vertex_total);
      REG_POS_FORMAT: prdata = 32'(cfg_r.position_format);
      REG_ATTR_FLAGS: prdata = 32'(cfg_r.attribute_flags);
      REG_TEX_COUNT:  prdata = 32'(cfg_r.tex_set_count);
      REG_TEX_SIZES:  prdata = 32'(cfg_r.tex_set_sizes);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prim_kind       <= PRIM_LIST;
      cfg_r.indexed_mode    <= 1'b0;
      cfg_r.vertex_total    <= '0;
      cfg_r.position_format <= 3'd1;
      cfg_r.attribute_flags <= '0;
      cfg_r.tex_set_count   <= '0;
      cfg_r.tex_set_sizes   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tpa_fmt_dec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_fmt_dec
// Decodes the vertex format registers into stride, colour and uv offsets.
// ----------------------------------------------------------------------------
module tpa_fmt_dec
  import tpa_pkg::*;
(
  input  wire logic clk,
  input  cfg_t      cfg,
  output fmt_t      fmt
);

  fmt_t                  fmt_r;
  fmt_t                  fmt_nxt;
  logic [TexCntBits-1:0] n_sets;
  logic [StrideBits-1:0] set_bytes [MaxTexSets];

  // clamp set count
  assign n_sets = (cfg.tex_set_count > TexCntBits'(MaxTexSets)) ?
                  TexCntBits'(MaxTexSets) : cfg.tex_set_count;

  always_comb begin
    for (int i = 0; i < MaxTexSets; i++) begin
      set_bytes[i] = (TexCntBits'(i) < n_sets) ?
                     StrideBits'(tex_set_bytes(cfg.tex_set_sizes[2*i +: 2])) : '0;
    end
  end

  always_comb begin
    fmt_nxt.colour_off = pos_bytes(cfg.position_format)
                       + (cfg.attribute_flags[0] ? SubOffBits'(12) : '0);
    fmt_nxt.uv_off     = fmt_nxt.colour_off
                       + (cfg.attribute_flags[1] ? SubOffBits'(4) : '0)
                       + (cfg.attribute_flags[2] ? SubOffBits'(4) : '0);
    fmt_nxt.stride     = StrideBits'(fmt_nxt.uv_off);
    for (int i = 0; i < MaxTexSets; i++) begin
      fmt_nxt.stride = fmt_nxt.stride + set_bytes[i];
    end
  end

  // config is to be written only while idle (the block does not enforce this), so a free-running register is enough
  always_ff @(posedge clk) begin
    fmt_r <= fmt_nxt;
  end

  assign fmt = fmt_r;

endmodule
`default_nettype wire

// ===== rtl/tpa_assemble.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_assemble
// Input register, call state and triangle selection for list/fan/strip.
// ----------------------------------------------------------------------------
module tpa_assemble
  import tpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [IndexBits-1:0] in_vertex_index,
  input  wire logic                 in_end_of_call,
  input  cfg_t                      cfg,
  input  wire logic                 ds_ready,
  output tri_t                      tri_out
);

  // input beat register
  logic                 in_v_r,   in_v_nxt;
  logic [IndexBits-1:0] idx_r;
  logic                 last_r;

  // call state
  logic [VtxBits-1:0] pos_cnt_r,  pos_cnt_nxt;
  logic [1:0]         phase_r,    phase_nxt;     // position mod 3
  logic [VtxBits-1:0] older_r,    older_nxt;
  logic               older_vld_r, older_vld_nxt;
  logic [VtxBits-1:0] newer_r,    newer_nxt;
  logic               newer_vld_r, newer_vld_nxt;
  logic [VtxBits-1:0] anchor_r,   anchor_nxt;
  logic               anchor_vld_r, anchor_vld_nxt;
  logic               dropped_r,  dropped_nxt;

  tri_t               tri_r, tri_nxt;

  logic               step;
  logic               tri_adv;
  logic               sat;
  logic [VtxBits-1:0] cur;
  logic               emit;
  logic [VtxBits-1:0] va, vb, vc;
  logic               tri_ok;

  assign tri_adv  = tri_r.vld & ds_ready;
  assign step     = in_v_r & (~tri_r.vld | tri_adv);
  assign in_stall = in_v_r & ~step;
  assign tri_out  = tri_r;

  assign sat = (pos_cnt_r == PosMax);
  assign cur = cfg.indexed_mode ? VtxBits'(idx_r) : pos_cnt_r;

  // triangle selection
  always_comb begin
    emit           = 1'b0;
    va             = '0;
    vb             = '0;
    vc             = '0;
    anchor_nxt     = anchor_r;
    anchor_vld_nxt = anchor_vld_r;
    dropped_nxt    = dropped_r;
    unique case (cfg.prim_kind)
      PRIM_LIST: begin
        if (phase_r == 2'd2 && older_vld_r && newer_vld_r) begin
          emit = 1'b1;
          va   = older_r;
          vb   = newer_r;
          vc   = cur;
        end
      end
      PRIM_FAN: begin
        if (pos_cnt_r == '0) begin
          anchor_nxt     = cur;
          anchor_vld_nxt = 1'b1;
          if (!(cur < cfg.vertex_total)) dropped_nxt = 1'b1;
        end else if (pos_cnt_r >= VtxBits'(2) && anchor_vld_r && newer_vld_r
                     && !dropped_r) begin
          emit = 1'b1;
          va   = anchor_r;
          vb   = newer_r;
          vc   = cur;
        end
      end
      PRIM_STRIP: begin
        if (pos_cnt_r >= VtxBits'(2) && older_vld_r && newer_vld_r) begin
          emit = 1'b1;
          va   = older_r;
          // odd triangles swap the last two vertices
          vb   = pos_cnt_r[0] ? cur : newer_r;
          vc   = pos_cnt_r[0] ? newer_r : cur;
        end
      end
      PRIM_OTHER: ;
      default: ;
    endcase
  end

  assign tri_ok = emit && (cfg.position_format != PosFmtRhw)
                  && (va < cfg.vertex_total) && (vb < cfg.vertex_total)
                  && (vc < cfg.vertex_total);

  // state advance
  always_comb begin
    pos_cnt_nxt   = pos_cnt_r;
    phase_nxt     = phase_r;
    older_nxt     = older_r;
    older_vld_nxt = older_vld_r;
    newer_nxt     = newer_r;
    newer_vld_nxt = newer_vld_r;
    tri_nxt       = tri_r;
    if (tri_adv) tri_nxt.vld = 1'b0;
    if (step) begin
      if (!sat) begin
        pos_cnt_nxt   = pos_cnt_r + VtxBits'(1);
        phase_nxt     = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
        older_nxt     = newer_r;
        older_vld_nxt = newer_vld_r;
        newer_nxt     = cur;
        newer_vld_nxt = 1'b1;
        tri_nxt.vld   = tri_ok;
        tri_nxt.a     = va;
        tri_nxt.b     = vb;
        tri_nxt.c     = vc;
      end
      if (last_r) begin
        pos_cnt_nxt   = '0;
        phase_nxt     = '0;
        older_nxt     = '0;
        older_vld_nxt = 1'b0;
        newer_nxt     = '0;
        newer_vld_nxt = 1'b0;
      end
    end
  end

  assign in_v_nxt = (in_valid & ~in_stall) | (in_v_r & ~step);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      idx_r  <= in_vertex_index;
      last_r <= in_end_of_call;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      tri_r        <= '0;
      pos_cnt_r    <= '0;
      phase_r      <= '0;
      older_r      <= '0;
      older_vld_r  <= 1'b0;
      newer_r      <= '0;
      newer_vld_r  <= 1'b0;
      anchor_r     <= '0;
      anchor_vld_r <= 1'b0;
      dropped_r    <= 1'b0;
    end else begin
      in_v_r      <= in_v_nxt;
      tri_r       <= tri_nxt;
      pos_cnt_r   <= pos_cnt_nxt;
      phase_r     <= phase_nxt;
      older_r     <= older_nxt;
      older_vld_r <= older_vld_nxt;
      newer_r     <= newer_nxt;
      newer_vld_r <= newer_vld_nxt;
      if (step && last_r) begin
        anchor_r     <= '0;
        anchor_vld_r <= 1'b0;
        dropped_r    <= 1'b0;
      end else if (step && !sat) begin
        anchor_r     <= anchor_nxt;
        anchor_vld_r <= anchor_vld_nxt;
        dropped_r    <= dropped_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tpa_offset.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpa_offset
// Scales the three vertex numbers by the stride; result register.
// ----------------------------------------------------------------------------
module tpa_offset
  import tpa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  tri_t                        tri_in,
  output logic                        ds_ready,
  input  fmt_t                        fmt,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [OffBits-1:0]          out_first_offset,
  output logic [OffBits-1:0]          out_second_offset,
  output logic [OffBits-1:0]          out_third_offset,
  output logic [StrideBits-1:0]       out_vertex_stride,
  output logic [SubOffBits-1:0]       out_colour_offset,
  output logic [SubOffBits-1:0]       out_uv_offset
);

  localparam int ProdBits = VtxBits + StrideBits;

  logic                  out_v_r, out_v_nxt;
  logic                  load;
  logic [ProdBits-1:0]   prod_a, prod_b, prod_c;
  logic [OffBits-1:0]    off_a_r, off_b_r, off_c_r;
  fmt_t                  fmt_r;

  assign ds_ready  = ~out_v_r | ~out_stall;
  assign load      = tri_in.vld & ds_ready;
  assign out_v_nxt = load | (out_v_r & out_stall);

  // three 17x8 lanes, offsets wrap to 24 bits
  assign prod_a = ProdBits'(tri_in.a) * ProdBits'(fmt.stride);
  assign prod_b = ProdBits'(tri_in.b) * ProdBits'(fmt.stride);
  assign prod_c = ProdBits'(tri_in.c) * ProdBits'(fmt.stride);

  always_ff @(posedge clk) begin
    if (load) begin
      off_a_r <= prod_a[OffBits-1:0];
      off_b_r <= prod_b[OffBits-1:0];
      off_c_r <= prod_c[OffBits-1:0];
      fmt_r   <= fmt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_first_offset  = off_a_r;
  assign out_second_offset = off_b_r;
  assign out_third_offset  = off_c_r;
  assign out_vertex_stride = fmt_r.stride;
  assign out_colour_offset = fmt_r.colour_off;
  assign out_uv_offset     = fmt_r.uv_off;

endmodule
`default_nettype wire

// ===== rtl/triangle_primitive_assembler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_primitive_assembler_core
// Builds list, fan and strip triangles from a vertex beat stream and
// returns the vertex byte offsets and format offsets of each triangle.
// ----------------------------------------------------------------------------
// One vertex beat is taken per clock while in_stall is low, and each beat
// yields at most one result beat; sustained rate is one beat per cycle while
// out_stall stays low. An accepted input beat is loaded into the input
// register, then the assembly register, then the offset register, whose
// outputs show the result beat. Every stage carries its own valid, so a held
// result only backs up the pipe stage by stage and in_stall rises only when
// all three stages are full. Beats that complete no valid triangle vanish at
// the assembly stage. Configuration is an APB slave (pready always high,
// registers at byte address 4*index) and is to be written between calls,
// once the pipe has drained; the format decode is registered after the
// config register.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler_core
  import tpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [AddrBits-1:0]   paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // vertex beats
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [IndexBits-1:0]  in_vertex_index,
  input  wire logic                  in_end_of_call,
  // triangle beats
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OffBits-1:0]         out_first_offset,
  output logic [OffBits-1:0]         out_second_offset,
  output logic [OffBits-1:0]         out_third_offset,
  output logic [StrideBits-1:0]      out_vertex_stride,
  output logic [SubOffBits-1:0]      out_colour_offset,
  output logic [SubOffBits-1:0]      out_uv_offset
);

  cfg_t cfg;
  fmt_t fmt;
  tri_t tri_w;
  logic ds_ready;

  // register bank
  tpa_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stride / colour / uv decode, registered
  tpa_fmt_dec u_fmt (
    .clk (clk),
    .cfg (cfg),
    .fmt (fmt)
  );

  // input register + call state; picks the triangle and checks its vertices
  tpa_assemble u_asm (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex_index (in_vertex_index),
    .in_end_of_call  (in_end_of_call),
    .cfg             (cfg),
    .ds_ready        (ds_ready),
    .tri_out         (tri_w)
  );

  // index * stride for the three corners, result register
  tpa_offset u_off (
    .clk               (clk),
    .rst_n             (rst_n),
    .tri_in            (tri_w),
    .ds_ready          (ds_ready),
    .fmt               (fmt),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_first_offset  (out_first_offset),
    .out_second_offset (out_second_offset),
    .out_third_offset  (out_third_offset),
    .out_vertex_stride (out_vertex_stride),
    .out_colour_offset (out_colour_offset),
    .out_uv_offset     (out_uv_offset)
  );

endmodule
`default_nettype wire
